@@ rtl/kde_pkg.sv @@
// shared types, codes and defaults for the keyed deque engine
`timescale 1ns / 1ps
package kde_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int KEY_W        = 16;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT_AFTER = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] ride;
    logic [KEY_W-1:0] customer;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    entry_t                 entry;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_NEXT_RD,
    S_POP_RD,
    S_REPORT
  } state_t;

endpackage

@@ rtl/kde_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module kde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/kde_ctrl.sv @@
// sequencer: circular store pointers, key scan and removal shift
`timescale 1ns / 1ps
module kde_ctrl #(
  parameter int CAPACITY = kde_pkg::DEF_CAPACITY,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kde_pkg::KIND_W-1:0]  in_kind,
  input  logic [kde_pkg::KEY_W-1:0]   in_key,
  input  logic [kde_pkg::KEY_W-1:0]   in_customer,
  input  logic [kde_pkg::KEY_W-1:0]   in_ride,
  input  logic                        out_free,
  output logic                        res_valid,
  output kde_pkg::result_t            res,
  output logic                        mem_we,
  output logic [PW-1:0]               mem_waddr,
  output kde_pkg::entry_t             mem_wdata,
  output logic [PW-1:0]               mem_raddr,
  input  kde_pkg::entry_t             mem_rdata
);
  import kde_pkg::*;

  state_t state, state_next;
  logic [PW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [KIND_W-1:0] op_kind, op_kind_next;
  logic [KEY_W-1:0] op_key, op_key_next;
  logic [KEY_W-1:0] op_customer, op_customer_next;
  logic [KEY_W-1:0] op_ride, op_ride_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] cmp_idx, cmp_idx_next;
  logic cmp_valid, cmp_valid_next;
  logic [CW-1:0] wr_idx, wr_idx_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  entry_t res_entry, res_entry_next;

  logic [CW-1:0] rd_sel;
  logic [PW-1:0] head_dec, head_inc;
  logic is_empty, is_full, match, cmp_last, shift_last;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  // logical position to ram address, position is at most the capacity
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [CW-1:0] idx);
    logic [PW+1:0] sum;
    sum = (PW+2)'(base) + (PW+2)'(idx);
    if (sum >= (PW+2)'(CAPACITY)) begin
      sum = sum - (PW+2)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign head_dec   = (head == '0) ? PW'(CAPACITY - 1) : head - 1'b1;
  assign head_inc   = (head == PW'(CAPACITY - 1)) ? '0 : head + 1'b1;
  assign is_empty   = (count == '0);
  assign is_full    = (count == CW'(CAPACITY));
  assign match      = (mem_rdata.key == op_key);
  assign cmp_last   = (cmp_idx == count - 1'b1);
  assign shift_last = (wr_idx == count - CW'(2));
  assign count_ext  = {{COUNT_OUT_W{1'b0}}, count};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_kind)
          KIND_POP_FRONT: state_next = is_empty ? S_REPORT : S_POP_RD;
          KIND_REMOVE, KIND_LOOKUP, KIND_NEXT_AFTER: begin
            state_next = is_empty ? S_REPORT : S_SCAN;
          end
          default: state_next = S_REPORT;
        endcase
      end
      S_SCAN: begin
        if (cmp_valid) begin
          if (match) begin
            case (op_kind)
              KIND_REMOVE:     state_next = cmp_last ? S_REPORT : S_SHIFT;
              KIND_NEXT_AFTER: state_next = S_NEXT_RD;
              default:         state_next = S_REPORT;
            endcase
          end else if (cmp_last) begin
            state_next = S_REPORT;
          end
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_next = S_REPORT;
        end
      end
      S_NEXT_RD: state_next = S_REPORT;
      S_POP_RD:  state_next = S_REPORT;
      S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_next        = head;
    count_next       = count;
    op_kind_next     = op_kind;
    op_key_next      = op_key;
    op_customer_next = op_customer;
    op_ride_next     = op_ride;
    rd_idx_next      = rd_idx;
    cmp_idx_next     = cmp_idx;
    cmp_valid_next   = cmp_valid;
    wr_idx_next      = wr_idx;
    res_status_next  = res_status;
    res_entry_next   = res_entry;
    rd_sel           = rd_idx;
    mem_we           = 1'b0;
    mem_waddr        = phys(head, wr_idx);
    mem_wdata        = mem_rdata;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_kind_next     = in_kind;
          op_key_next      = in_key;
          op_customer_next = in_customer;
          op_ride_next     = in_ride;
        end
      end
      S_DECODE: begin
        res_status_next = ST_OK;
        res_entry_next  = '0;
        rd_idx_next     = '0;
        cmp_valid_next  = 1'b0;
        mem_wdata       = '{ride: op_ride, customer: op_customer, key: op_key};
        case (op_kind)
          KIND_PUSH_BACK: begin
            if (is_full) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = phys(head, count);
              count_next = count + 1'b1;
            end
          end
          KIND_PUSH_FRONT: begin
            if (is_full) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = head_dec;
              head_next  = head_dec;
              count_next = count + 1'b1;
            end
          end
          KIND_POP_FRONT: begin
            rd_sel = '0;
            if (is_empty) begin
              res_status_next = ST_EMPTY;
            end
          end
          KIND_REMOVE, KIND_LOOKUP, KIND_NEXT_AFTER: begin
            if (is_empty) begin
              res_status_next = ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        rd_idx_next    = rd_idx + 1'b1;
        cmp_idx_next   = rd_idx;
        cmp_valid_next = 1'b1;
        if (cmp_valid) begin
          if (match) begin
            res_entry_next = mem_rdata;
            case (op_kind)
              KIND_REMOVE: begin
                if (cmp_last) begin
                  count_next = count - 1'b1;
                end else begin
                  wr_idx_next = cmp_idx;
                end
              end
              KIND_NEXT_AFTER: begin
                rd_sel = cmp_last ? '0 : cmp_idx + 1'b1;
              end
              default: begin
              end
            endcase
          end else if (cmp_last) begin
            res_status_next = ST_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        if (shift_last) begin
          count_next = count - 1'b1;
        end else begin
          wr_idx_next = wr_idx + 1'b1;
          rd_idx_next = rd_idx + 1'b1;
        end
      end
      S_NEXT_RD: begin
        res_entry_next = mem_rdata;
      end
      S_POP_RD: begin
        res_entry_next = mem_rdata;
        head_next      = head_inc;
        count_next     = count - 1'b1;
      end
      S_REPORT: begin
        res_valid = out_free;
      end
      default: begin
      end
    endcase
  end

  assign mem_raddr       = phys(head, rd_sel);
  assign res.status      = res_status;
  assign res.entry       = res_entry;
  assign res.entry_count = count_ext[COUNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_kind     <= op_kind_next;
    op_key      <= op_key_next;
    op_customer <= op_customer_next;
    op_ride     <= op_ride_next;
    rd_idx      <= rd_idx_next;
    cmp_idx     <= cmp_idx_next;
    wr_idx      <= wr_idx_next;
    res_status  <= res_status_next;
    res_entry   <= res_entry_next;
  end

endmodule

@@ rtl/keyed_deque_engine_unit.sv @@
// Look up and next after scan up to the matched position; a missed key and remove walk
// the whole store (count before the request). Request time is set by the single ram read
// port that the key scan and the removal shift walk one entry per cycle.
// One request at a time; a finished result waits in the output register while the
// next request is taken. Synchronous reset empties the store at once, no clearing pass.
`timescale 1ns / 1ps
module keyed_deque_engine_unit #(
  parameter int CAPACITY = kde_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // ticket_key, customer_tag, ride_tag
  input  logic [2:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // found_key, found_customer, found_ride, entry_count, pad
  output logic [1:0]  m_axis_tuser   // status
);
  import kde_pkg::*;

  localparam int PW = $clog2(CAPACITY);

  logic out_free, res_valid;
  result_t res, out_res;
  logic mem_we;
  logic [PW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  kde_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_kind     (s_axis_tuser),
    .in_key      (s_axis_tdata[15:0]),
    .in_customer (s_axis_tdata[31:16]),
    .in_ride     (s_axis_tdata[47:32]),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  kde_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.entry_count, out_res.entry.ride,
                         out_res.entry.customer, out_res.entry.key};
  assign m_axis_tuser = out_res.status;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the keyed deque engine with a deque model and random traffic
`timescale 1ns / 1ps
module testbench;
  import kde_pkg::*;

  localparam int CAP            = DEF_CAPACITY;
  localparam int RANDOM_ITEMS   = 630;
  localparam int POOL_SIZE      = 12;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 2 * CAP + 72;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef enum int {PLAN_FILL, PLAN_DRAIN, PLAN_MIX} plan_t;

  class deque_scoreboard;
    entry_t      slots[CAP];
    int unsigned fill;
    result_t     expected_results[$];
    int unsigned failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void take_out(int unsigned pos);
      for (int unsigned i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [KEY_W-1:0] customer, logic [KEY_W-1:0] ride);
      result_t     want;
      int unsigned pos;
      want        = '0;
      want.status = ST_OK;
      pos         = 0;
      case (kind)
        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
          if (fill >= CAP) begin
            want.status = ST_FULL;
          end else begin
            if (kind == KIND_PUSH_FRONT) begin
              for (int unsigned i = fill; i > 0; i--) slots[i] = slots[i - 1];
            end else begin
              pos = fill;
            end
            slots[pos].key      = key;
            slots[pos].customer = customer;
            slots[pos].ride     = ride;
            fill++;
          end
        end
        KIND_REMOVE, KIND_POP_FRONT, KIND_LOOKUP, KIND_NEXT_AFTER: begin
          if (fill == 0) begin
            want.status = ST_EMPTY;
          end else begin
            if (kind != KIND_POP_FRONT) begin
              while (pos < fill && slots[pos].key != key) pos++;
            end
            if (pos == fill) begin
              want.status = ST_NOTFOUND;
            end else begin
              if (kind == KIND_NEXT_AFTER) pos = (pos + 1 == fill) ? 0 : pos + 1;
              want.entry = slots[pos];
              if (kind == KIND_REMOVE || kind == KIND_POP_FRONT) take_out(pos);
            end
          end
        end
        default: ;
      endcase
      want.entry_count = 7'(fill);
      expected_results.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        complain($sformatf("unexpected result status %0d key %h cust %h ride %h count %0d",
                           got.status, got.entry.key, got.entry.customer, got.entry.ride,
                           got.entry_count));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.entry.key !== want.entry.key ||
          got.entry.customer !== want.entry.customer || got.entry.ride !== want.entry.ride ||
          got.entry_count !== want.entry_count) begin
        complain($sformatf({"expected status %0d key %h cust %h ride %h count %0d, ",
                            "got status %0d key %h cust %h ride %h count %0d"},
                           want.status, want.entry.key, want.entry.customer, want.entry.ride,
                           want.entry_count, got.status, got.entry.key, got.entry.customer,
                           got.entry.ride, got.entry_count));
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // ticket_key, customer_tag, ride_tag
  logic [2:0]  s_axis_tuser = '0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // found_key, found_customer, found_ride, entry_count, pad
  logic [1:0]  m_axis_tuser;  // status

  deque_scoreboard sb;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  bit               sender_calm = 1'b0;
  int unsigned      quiet_cycles = 0;

  keyed_deque_engine_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [KEY_W-1:0] customer, input logic [KEY_W-1:0] ride);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ride, customer, key};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(kind, key, customer, ride);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int          stall;
    int unsigned taken;
    result_t     got;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if ((taken / 40) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.status            = m_axis_tuser;
      got.entry.key         = m_axis_tdata[15:0];
      got.entry.customer    = m_axis_tdata[31:16];
      got.entry.ride        = m_axis_tdata[47:32];
      got.entry_count       = m_axis_tdata[54:48];
      sb.check_result(got);
      taken++;
    end
  end

  initial begin
    int               issued;
    int               phase;
    int               span;
    int               roll;
    plan_t            plan;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    sb          = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty store, unused kinds, extremes, duplicates, wrap and misses
    send_request(KIND_POP_FRONT, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_REMOVE, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_request(KIND_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000);
    send_request(KIND_NEXT_AFTER, 16'h1234, 16'h0000, 16'h0000);
    send_request(KIND_UNUSED_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(KIND_UNUSED_HI, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_PUSH_BACK, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_NEXT_AFTER, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_PUSH_FRONT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(KIND_PUSH_BACK, 16'h1234, 16'hA5A5, 16'h5A5A);
    send_request(KIND_PUSH_BACK, 16'h1234, 16'h0001, 16'h0002);
    send_request(KIND_PUSH_BACK, 16'h8001, 16'h7FFE, 16'hC003);
    send_request(KIND_LOOKUP, 16'h1234, 16'h0000, 16'h0000);
    send_request(KIND_NEXT_AFTER, 16'h1234, 16'h0000, 16'h0000);
    send_request(KIND_NEXT_AFTER, 16'h8001, 16'h0000, 16'h0000);
    send_request(KIND_LOOKUP, 16'h7777, 16'h0000, 16'h0000);
    send_request(KIND_REMOVE, 16'h7777, 16'h0000, 16'h0000);
    send_request(KIND_NEXT_AFTER, 16'h7777, 16'h0000, 16'h0000);
    send_request(KIND_REMOVE, 16'h1234, 16'h0000, 16'h0000);
    send_request(KIND_LOOKUP, 16'h1234, 16'h0000, 16'h0000);
    send_request(KIND_POP_FRONT, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_REMOVE, 16'h8001, 16'h0000, 16'h0000);
    send_request(KIND_UNUSED_LO, 16'h5555, 16'hAAAA, 16'h5555);
    wait_for_drain();

    // random phases, the first one fills the store past capacity
    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      plan        = (phase == 0) ? PLAN_FILL : plan_t'($urandom_range(0, 2));
      span        = (phase == 0) ? 100 : $urandom_range(30, 90);
      sender_calm = (phase != 0) && ($urandom_range(0, 3) == 0);
      if (phase != 0 && $urandom_range(0, 4) == 0) wait_for_drain();
      for (int n = 0; n < span && issued < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          kind = KIND_NEXT_AFTER + 3'd1 + 3'($urandom_range(0, 1));
        end else begin
          case (plan)
            PLAN_FILL: begin
              if (roll < 90) begin
                kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
              end else begin
                kind = KIND_W'($urandom_range(KIND_REMOVE, KIND_NEXT_AFTER));
              end
            end
            PLAN_DRAIN: begin
              if (roll < 75) begin
                kind = $urandom_range(0, 1) ? KIND_REMOVE : KIND_POP_FRONT;
              end else begin
                kind = KIND_W'($urandom_range(KIND_PUSH_BACK, KIND_NEXT_AFTER));
              end
            end
            default: begin
              kind = KIND_W'($urandom_range(KIND_PUSH_BACK, KIND_NEXT_AFTER));
            end
          endcase
        end
        roll = $urandom_range(0, 99);
        if (kind != KIND_PUSH_BACK && kind != KIND_PUSH_FRONT && sb.fill > 0 && roll < 50) begin
          key = sb.slots[$urandom_range(0, sb.fill - 1)].key;
        end else if (roll < 85) begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          key = KEY_W'($urandom);
        end
        send_request(kind, key, 16'($urandom), 16'($urandom));
        if (kind <= KIND_NEXT_AFTER) issued++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
